// ----- rtl/cabs_pkg.sv -----
// Package for the class-aware box suppression block: sizes, config indexes,
// request and result records, back-end states. No dependencies.
package cabs_pkg;

  localparam int MAX_BOXES   = 1024;
  localparam int IDX_W       = $clog2(MAX_BOXES);
  localparam int CNT_W       = $clog2(MAX_BOXES + 1);
  localparam int SRC_W       = 10;
  localparam int RESULT_CAP  = 64;
  localparam int LIM_W       = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IOU_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESULTS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_LEFT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_TOP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd5;

  typedef struct packed {
    logic [15:0] iou_threshold;
    logic [6:0]  max_results;
    logic [14:0] pad_left;
    logic [14:0] pad_top;
    logic [14:0] frame_width;
    logic [14:0] frame_height;
  } cfg_t;

  // One classified request from the front end
  typedef struct packed {
    logic [63:0]      box;      // bottom, right, top, left from high to low
    logic [15:0]      score;
    logic [7:0]       cls;
    logic [IDX_W-1:0] idx;
    logic             store;
    logic             last;
    logic [CNT_W-1:0] count;
    logic             ovf;
  } rec_t;

  typedef struct packed {
    logic [63:0]      box;
    logic [15:0]      score;
    logic [7:0]       cls;
    logic [IDX_W-1:0] idx;
  } cand_t;

  typedef struct packed {
    logic [14:0]      left;
    logic [14:0]      top;
    logic [14:0]      right;
    logic [14:0]      bottom;
    logic [15:0]      score;
    logic [7:0]       cls;
    logic [SRC_W-1:0] src;
    logic             empty;
    logic             ovf;
    logic             last;
  } result_t;

  typedef enum logic [2:0] {
    BK_LOAD,
    BK_SCAN,
    BK_DRAIN,
    BK_MARK,
    BK_EMIT,
    BK_PREP,
    BK_FLUSH
  } back_state_t;

endpackage

// ----- rtl/class_aware_box_suppression.sv -----
// Top level of per-class greedy box suppression: config registers, front end,
// request queue and back end. Depends on cabs_pkg, cabs_front, cabs_queue, cabs_back.
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid/tready       boxes, frame end on tlast
//   m_axis    out        m_axis_tvalid/tready       kept boxes, frame end on tlast
//   cfg       in         cfg_valid/cfg_ready        register index and data
//
// Candidates load at one per cycle while the queue has room.
// After the frame end, each pass scans n stored boxes through the single-read-port
// stores and the 5-stage overlap pipeline; one pass runs per kept box plus one final
// pass unless the result limit (max_results clamped to 1..64) is reached, which also
// bounds the passes that emit. New candidates wait in the queue, then at the input,
// until the frame's last result is staged. Synchronous reset; no clearing pass.
module class_aware_box_suppression (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // box_left, box_top, box_right, box_bottom,
                                      // box_score, box_class
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // out_left, out_top, out_right, out_bottom,
                                      // out_score, out_class, source_index, zero pad
  output logic [1:0]  m_axis_tuser,   // empty_frame, overflow
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cabs_pkg::cfg_t    cfg;
  cabs_pkg::rec_t    fr_rec;
  cabs_pkg::rec_t    q_rec;
  cabs_pkg::result_t res;
  logic              fr_push;
  logic              q_ready;
  logic              q_valid;
  logic              bk_ready;

  assign cfg_ready = 1'b1;

  // Hold config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.iou_threshold <= 16'd29491;
      cfg.max_results   <= 7'd64;
      cfg.pad_left      <= 15'd0;
      cfg.pad_top       <= 15'd0;
      cfg.frame_width   <= 15'd10240;
      cfg.frame_height  <= 15'd10240;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cabs_pkg::CFG_IOU_THRESHOLD: cfg.iou_threshold <= cfg_data;
        cabs_pkg::CFG_MAX_RESULTS:   cfg.max_results   <= cfg_data[6:0];
        cabs_pkg::CFG_PAD_LEFT:      cfg.pad_left      <= cfg_data[14:0];
        cabs_pkg::CFG_PAD_TOP:       cfg.pad_top       <= cfg_data[14:0];
        cabs_pkg::CFG_FRAME_WIDTH:   cfg.frame_width   <= cfg_data[14:0];
        cabs_pkg::CFG_FRAME_HEIGHT:  cfg.frame_height  <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  cabs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .push       (fr_push),
    .push_ready (q_ready),
    .rec        (fr_rec)
  );

  cabs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_push),
    .wr_ready (q_ready),
    .wr_data  (fr_rec),
    .rd_valid (q_valid),
    .rd_ready (bk_ready),
    .rd_data  (q_rec)
  );

  cabs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec_valid (q_valid),
    .rec_ready (bk_ready),
    .rec       (q_rec),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  // Pack the result request
  assign m_axis_tdata = {2'b00, res.src, res.cls, res.score,
                         res.bottom, res.right, res.top, res.left};
  assign m_axis_tuser = {res.ovf, res.empty};
  assign m_axis_tlast = res.last;

endmodule

// ----- rtl/cabs_front.sv -----
// Front end: takes candidate requests, assigns store slots, flags capacity
// overflow and frame ends. Depends on cabs_pkg.
module cabs_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [87:0]    in_data,
  input  logic           in_last,
  output logic           push,
  input  logic           push_ready,
  output cabs_pkg::rec_t rec
);

  logic [cabs_pkg::CNT_W-1:0] count;
  logic                       ovf;
  logic                       store;

  assign in_ready = push_ready;
  assign push     = in_valid && push_ready;
  assign store    = count < cabs_pkg::CNT_W'(cabs_pkg::MAX_BOXES);

  // Build the classified request
  always_comb begin
    rec.box   = in_data[63:0];
    rec.score = in_data[79:64];
    rec.cls   = in_data[87:80];
    rec.idx   = count[cabs_pkg::IDX_W-1:0];
    rec.store = store;
    rec.last  = in_last;
    rec.count = store ? count + 1'b1 : count;
    rec.ovf   = ovf || !store;
  end

  // Advance the per-frame fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (push) begin
      if (in_last) begin
        count <= '0;
        ovf   <= 1'b0;
      end else begin
        count <= rec.count;
        ovf   <= rec.ovf;
      end
    end
  end

endmodule

// ----- rtl/cabs_queue.sv -----
// Short request queue between the front and back ends.
// Depends on cabs_pkg.
module cabs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  cabs_pkg::rec_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output cabs_pkg::rec_t rd_data
);

  cabs_pkg::rec_t              slots [cabs_pkg::QUEUE_DEPTH];
  logic [cabs_pkg::QPTR_W-1:0] wr_ptr;
  logic [cabs_pkg::QPTR_W-1:0] rd_ptr;
  logic [cabs_pkg::QPTR_W:0]   fill;
  logic                        do_wr;
  logic                        do_rd;

  assign wr_ready = fill != (cabs_pkg::QPTR_W + 1)'(cabs_pkg::QUEUE_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Hold payload
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (cabs_pkg::QPTR_W + 1)'(do_wr) - (cabs_pkg::QPTR_W + 1)'(do_rd);
    end
  end

endmodule

// ----- rtl/cabs_back.sv -----
// Back end: box stores, greedy per-class suppression by repeated scans with a
// pipelined overlap test, clamping and result staging. Depends on cabs_pkg.
module cabs_back (
  input  logic              clk,
  input  logic              rst,
  input  cabs_pkg::cfg_t    cfg,
  input  logic              rec_valid,
  output logic              rec_ready,
  input  cabs_pkg::rec_t    rec,
  output logic              res_valid,
  input  logic              res_ready,
  output cabs_pkg::result_t res
);

  localparam int IW = cabs_pkg::IDX_W;
  localparam int CW = cabs_pkg::CNT_W;

  cabs_pkg::back_state_t state, state_next;

  // Stores
  logic [63:0] box_mem   [cabs_pkg::MAX_BOXES];
  logic [15:0] score_mem [cabs_pkg::MAX_BOXES];
  logic [7:0]  class_mem [cabs_pkg::MAX_BOXES];
  logic        dead_mem  [cabs_pkg::MAX_BOXES];
  logic [63:0] box_q;
  logic [15:0] score_q;
  logic [7:0]  class_q;
  logic        dead_q;

  logic          ld_we;
  logic          dead_we;
  logic [IW-1:0] dead_wa;
  logic          dead_wd;

  // Frame and scan control
  logic [CW-1:0] n;
  logic [CW-1:0] rd_idx;
  logic          issue;
  logic          ovf_frame;
  logic          have_kept;
  cabs_pkg::cand_t kept;
  logic signed [33:0] area_a;
  logic          best_v;
  cabs_pkg::cand_t best;
  logic [cabs_pkg::LIM_W-1:0] emitted;
  logic [cabs_pkg::LIM_W-1:0] limit;
  logic          pend_v;
  cabs_pkg::result_t pend;
  logic          out_free;
  logic          pipe_busy;
  logic          res_load;
  cabs_pkg::result_t fin;

  // Pipeline stages
  logic          s1_v;
  logic [IW-1:0] s1_idx;
  logic          s2_v, s3_v, s4_v, s5_v;
  cabs_pkg::cand_t s2_c, s3_c, s4_c, s5_c;
  logic          s2_alive, s3_alive, s4_alive, s5_alive;
  logic          s2_same, s3_same, s4_same, s5_same;
  logic [15:0]   s2_w, s2_h;
  logic signed [16:0] s2_dx, s2_dy;
  logic [31:0]   s3_inter, s4_inter, s5_inter;
  logic signed [33:0] s3_area_b;
  logic signed [35:0] s4_uni;
  logic          s5_pos;
  logic [32:0]   s5_pl, s5_ph;

  // Stage 1 terms
  logic signed [15:0] bx1, by1, bx2, by2, kx1, ky1, kx2, ky2;
  logic signed [15:0] mnx, mxx, mny, mxy;
  logic signed [16:0] ix, iy;
  cabs_pkg::cand_t    s1_c;

  // Stage 5 terms
  logic [50:0] prod;
  logic [50:0] lhs;
  logic        sup;
  logic        take;

  // Emission terms
  logic signed [17:0] x1s, y1s, x2s, y2s;
  logic [14:0]        x1, y1, x2, y2;
  logic               nondeg;
  logic signed [16:0] kdx, kdy;
  cabs_pkg::result_t  cur;

  assign rec_ready = state == cabs_pkg::BK_LOAD;
  assign ld_we     = rec_ready && rec_valid && rec.store;
  assign issue     = state == cabs_pkg::BK_SCAN;
  assign out_free  = !res_valid || res_ready;
  assign pipe_busy = s1_v || s2_v || s3_v || s4_v || s5_v;
  assign res_load  = (state == cabs_pkg::BK_EMIT && nondeg && pend_v && out_free) ||
                     (state == cabs_pkg::BK_FLUSH && out_free);

  always_comb begin
    if (cfg.max_results == '0) begin
      limit = cabs_pkg::LIM_W'(1);
    end else if (cfg.max_results > cabs_pkg::LIM_W'(cabs_pkg::RESULT_CAP)) begin
      limit = cabs_pkg::LIM_W'(cabs_pkg::RESULT_CAP);
    end else begin
      limit = cfg.max_results;
    end
  end

  // Select the suppression-mark write
  always_comb begin
    dead_we = 1'b0;
    dead_wa = rec.idx;
    dead_wd = 1'b0;
    if (ld_we) begin
      dead_we = 1'b1;
    end else if (state == cabs_pkg::BK_MARK && best_v) begin
      dead_we = 1'b1;
      dead_wa = best.idx;
      dead_wd = 1'b1;
    end else if (s5_v && sup) begin
      dead_we = 1'b1;
      dead_wa = s5_c.idx;
      dead_wd = 1'b1;
    end
  end

  // Write and read the stores
  always_ff @(posedge clk) begin
    if (ld_we) begin
      box_mem[rec.idx]   <= rec.box;
      score_mem[rec.idx] <= rec.score;
      class_mem[rec.idx] <= rec.cls;
    end
    if (dead_we) begin
      dead_mem[dead_wa] <= dead_wd;
    end
    box_q   <= box_mem[rd_idx[IW-1:0]];
    score_q <= score_mem[rd_idx[IW-1:0]];
    class_q <= class_mem[rd_idx[IW-1:0]];
    dead_q  <= dead_mem[rd_idx[IW-1:0]];
  end

  // Stage 1: overlap extents against the kept box
  always_comb begin
    bx1 = signed'(box_q[15:0]);
    by1 = signed'(box_q[31:16]);
    bx2 = signed'(box_q[47:32]);
    by2 = signed'(box_q[63:48]);
    kx1 = signed'(kept.box[15:0]);
    ky1 = signed'(kept.box[31:16]);
    kx2 = signed'(kept.box[47:32]);
    ky2 = signed'(kept.box[63:48]);
    mnx = (kx2 < bx2) ? kx2 : bx2;
    mxx = (kx1 > bx1) ? kx1 : bx1;
    mny = (ky2 < by2) ? ky2 : by2;
    mxy = (ky1 > by1) ? ky1 : by1;
    ix  = 17'(mnx) - 17'(mxx);
    iy  = 17'(mny) - 17'(mxy);
    s1_c.box   = box_q;
    s1_c.score = score_q;
    s1_c.cls   = class_q;
    s1_c.idx   = s1_idx;
  end

  // Stage 5: threshold test and best-candidate pick
  always_comb begin
    prod = 51'({s5_ph, 17'b0}) + 51'(s5_pl);
    lhs  = 51'({s5_inter, 16'b0});
    sup  = have_kept && s5_same && s5_alive && s5_pos && (lhs > prod);
    take = s5_v && s5_alive && !sup && (!best_v || s5_c.score > best.score);
  end

  // Clamp the kept box into the frame
  always_comb begin
    x1s = 18'(signed'(kept.box[15:0]))  - signed'({3'b0, cfg.pad_left});
    y1s = 18'(signed'(kept.box[31:16])) - signed'({3'b0, cfg.pad_top});
    x2s = 18'(signed'(kept.box[47:32])) - signed'({3'b0, cfg.pad_left});
    y2s = 18'(signed'(kept.box[63:48])) - signed'({3'b0, cfg.pad_top});
    x1  = (x1s < 0) ? 15'd0 : x1s[14:0];
    y1  = (y1s < 0) ? 15'd0 : y1s[14:0];
    if (x2s < 0) begin
      x2 = 15'd0;
    end else if (x2s > signed'({3'b0, cfg.frame_width})) begin
      x2 = cfg.frame_width;
    end else begin
      x2 = x2s[14:0];
    end
    if (y2s < 0) begin
      y2 = 15'd0;
    end else if (y2s > signed'({3'b0, cfg.frame_height})) begin
      y2 = cfg.frame_height;
    end else begin
      y2 = y2s[14:0];
    end
    nondeg     = (x2 > x1) && (y2 > y1);
    kdx        = 17'(signed'(kept.box[47:32])) - 17'(signed'(kept.box[15:0]));
    kdy        = 17'(signed'(kept.box[63:48])) - 17'(signed'(kept.box[31:16]));
    cur.left   = x1;
    cur.top    = y1;
    cur.right  = x2;
    cur.bottom = y2;
    cur.score  = kept.score;
    cur.cls    = kept.cls;
    cur.src    = cabs_pkg::SRC_W'(kept.idx);
    cur.empty  = 1'b0;
    cur.ovf    = ovf_frame;
    cur.last   = 1'b0;
  end

  // Build the closing request: the held box, or the empty marker
  always_comb begin
    fin = pend;
    if (!pend_v) begin
      fin       = '0;
      fin.empty = 1'b1;
      fin.ovf   = ovf_frame;
    end
    fin.last = 1'b1;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      cabs_pkg::BK_LOAD: begin
        if (rec_valid && rec.last) state_next = cabs_pkg::BK_SCAN;
      end
      cabs_pkg::BK_SCAN: begin
        if (rd_idx == n - 1'b1) state_next = cabs_pkg::BK_DRAIN;
      end
      cabs_pkg::BK_DRAIN: begin
        if (!pipe_busy) state_next = cabs_pkg::BK_MARK;
      end
      cabs_pkg::BK_MARK: begin
        state_next = best_v ? cabs_pkg::BK_EMIT : cabs_pkg::BK_FLUSH;
      end
      cabs_pkg::BK_EMIT: begin
        if (!nondeg) begin
          state_next = cabs_pkg::BK_PREP;
        end else if (!pend_v || out_free) begin
          state_next = (emitted + 1'b1 == limit) ? cabs_pkg::BK_FLUSH : cabs_pkg::BK_PREP;
        end
      end
      cabs_pkg::BK_PREP: begin
        state_next = cabs_pkg::BK_SCAN;
      end
      cabs_pkg::BK_FLUSH: begin
        if (out_free) state_next = cabs_pkg::BK_LOAD;
      end
      default: state_next = cabs_pkg::BK_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cabs_pkg::BK_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Advance the scan pipeline
  always_ff @(posedge clk) begin
    s1_idx   <= rd_idx[IW-1:0];
    s2_c     <= s1_c;
    s2_alive <= !dead_q;
    s2_same  <= class_q == kept.cls;
    s2_w     <= (ix > 0) ? ix[15:0] : 16'd0;
    s2_h     <= (iy > 0) ? iy[15:0] : 16'd0;
    s2_dx    <= 17'(bx2) - 17'(bx1);
    s2_dy    <= 17'(by2) - 17'(by1);
    s3_c      <= s2_c;
    s3_alive  <= s2_alive;
    s3_same   <= s2_same;
    s3_inter  <= s2_w * s2_h;
    s3_area_b <= 34'(s2_dx) * 34'(s2_dy);
    s4_c     <= s3_c;
    s4_alive <= s3_alive;
    s4_same  <= s3_same;
    s4_inter <= s3_inter;
    s4_uni   <= 36'(area_a) + 36'(s3_area_b) - signed'(36'(s3_inter));
    s5_c     <= s4_c;
    s5_alive <= s4_alive;
    s5_same  <= s4_same;
    s5_inter <= s4_inter;
    s5_pos   <= s4_uni > 0;
    s5_pl    <= cfg.iou_threshold * s4_uni[16:0];
    s5_ph    <= cfg.iou_threshold * s4_uni[33:17];
  end

  // Frame control, best pick and result staging
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      s5_v      <= 1'b0;
      have_kept <= 1'b0;
      best_v    <= 1'b0;
      pend_v    <= 1'b0;
      res_valid <= 1'b0;
      emitted   <= '0;
      rd_idx    <= '0;
      n         <= '0;
      ovf_frame <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (take) begin
        best_v <= 1'b1;
        best   <= s5_c;
      end
      unique case (state)
        cabs_pkg::BK_LOAD: begin
          if (rec_valid && rec.last) begin
            n         <= rec.count;
            ovf_frame <= rec.ovf;
            have_kept <= 1'b0;
            best_v    <= 1'b0;
            pend_v    <= 1'b0;
            emitted   <= '0;
            rd_idx    <= '0;
          end
        end
        cabs_pkg::BK_SCAN: begin
          rd_idx <= rd_idx + 1'b1;
        end
        cabs_pkg::BK_DRAIN: begin
        end
        cabs_pkg::BK_MARK: begin
          if (best_v) begin
            kept      <= best;
            have_kept <= 1'b1;
          end
        end
        cabs_pkg::BK_EMIT: begin
          if (nondeg && (!pend_v || out_free)) begin
            if (pend_v) begin
              res <= pend;
            end
            pend    <= cur;
            pend_v  <= 1'b1;
            emitted <= emitted + 1'b1;
          end
        end
        cabs_pkg::BK_PREP: begin
          area_a <= 34'(kdx) * 34'(kdy);
          best_v <= 1'b0;
          rd_idx <= '0;
        end
        cabs_pkg::BK_FLUSH: begin
          if (out_free) begin
            res    <= fin;
            pend_v <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/cabs_checker.sv -----
// Port-level checks on the result channel of class_aware_box_suppression,
// attached by bind. No package dependency.
module cabs_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Empty marker closes the frame
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("empty result without frame end");

  // Empty marker carries no box
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("empty result with box data");

  // Emitted boxes are never degenerate
  a_nondeg: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |->
      (m_axis_tdata[44:30] > m_axis_tdata[14:0]) &&
      (m_axis_tdata[59:45] > m_axis_tdata[29:15]))
    else $error("degenerate box emitted");

endmodule

bind class_aware_box_suppression cabs_checker u_cabs_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- test/class_aware_box_suppression_test.sv -----
// Testbench for class_aware_box_suppression: drives candidate frames and config writes,
// predicts the kept boxes with a scoreboard class and checks every result.
// Depends on cabs_pkg and the block under test.
module class_aware_box_suppression_test;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [7:0]  cls;
    logic [15:0] score;
    logic [15:0] bottom;
    logic [15:0] right;
    logic [15:0] top;
    logic [15:0] left;
  } cand_box_t;

  // Predicts kept boxes per frame and holds them until they come out
  class nms_scoreboard;
    int unsigned         errors;
    cabs_pkg::result_t   kept_q[$];
    logic [15:0]         iou_thr;
    int unsigned         res_limit;
    int                  pad_l, pad_t, fw, fh;
    cand_box_t           boxes[cabs_pkg::MAX_BOXES];
    int unsigned         nbox;
    bit                  ovf;

    function new();
      errors = 0; nbox = 0; ovf = 0;
      iou_thr = 16'd29491; res_limit = 64;
      pad_l = 0; pad_t = 0; fw = 10240; fh = 10240;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        cabs_pkg::CFG_IOU_THRESHOLD: iou_thr = val;
        cabs_pkg::CFG_MAX_RESULTS:   res_limit = 32'(val[6:0]);
        cabs_pkg::CFG_PAD_LEFT:      pad_l = int'(val[14:0]);
        cabs_pkg::CFG_PAD_TOP:       pad_t = int'(val[14:0]);
        cabs_pkg::CFG_FRAME_WIDTH:   fw = int'(val[14:0]);
        cabs_pkg::CFG_FRAME_HEIGHT:  fh = int'(val[14:0]);
        default: ;
      endcase
    endfunction

    function bit overlaps(cand_box_t a, cand_box_t b);
      longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, w, h, inter, uni;
      ax1 = $signed(a.left); ay1 = $signed(a.top);
      ax2 = $signed(a.right); ay2 = $signed(a.bottom);
      bx1 = $signed(b.left); by1 = $signed(b.top);
      bx2 = $signed(b.right); by2 = $signed(b.bottom);
      w = ((ax2 < bx2) ? ax2 : bx2) - ((ax1 > bx1) ? ax1 : bx1);
      h = ((ay2 < by2) ? ay2 : by2) - ((ay1 > by1) ? ay1 : by1);
      if (w < 0) w = 0;
      if (h < 0) h = 0;
      inter = w * h;
      uni = (ax2 - ax1) * (ay2 - ay1) + (bx2 - bx1) * (by2 - by1) - inter;
      if (uni <= 0) return 0;
      return inter * 65536 > longint'(iou_thr) * uni;
    endfunction

    // Store one accepted candidate; at frame end sort, suppress and emit
    function void note_box(cand_box_t b, bit last);
      int unsigned       order[cabs_pkg::MAX_BOXES];
      bit                gone[cabs_pkg::MAX_BOXES];
      int unsigned       i, j, lim, cnt;
      longint            x1, y1, x2, y2;
      cabs_pkg::result_t r;
      if (nbox < cabs_pkg::MAX_BOXES) begin
        boxes[nbox] = b;
        nbox++;
      end else begin
        ovf = 1;
      end
      if (!last) return;
      for (i = 0; i < nbox; i++) begin
        j = i;
        while (j > 0 && boxes[order[j-1]].score < boxes[i].score) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
        gone[i] = 0;
      end
      for (i = 0; i < nbox; i++) begin
        if (gone[order[i]]) continue;
        for (j = i + 1; j < nbox; j++) begin
          if (gone[order[j]] || boxes[order[j]].cls != boxes[order[i]].cls) continue;
          if (overlaps(boxes[order[i]], boxes[order[j]])) gone[order[j]] = 1;
        end
      end
      lim = (res_limit == 0) ? 1 :
            ((res_limit > cabs_pkg::RESULT_CAP) ? cabs_pkg::RESULT_CAP : res_limit);
      cnt = 0;
      for (i = 0; i < nbox && cnt < lim; i++) begin
        if (gone[order[i]]) continue;
        x1 = longint'($signed(boxes[order[i]].left)) - pad_l;
        y1 = longint'($signed(boxes[order[i]].top)) - pad_t;
        x2 = longint'($signed(boxes[order[i]].right)) - pad_l;
        y2 = longint'($signed(boxes[order[i]].bottom)) - pad_t;
        if (x1 < 0) x1 = 0;
        if (y1 < 0) y1 = 0;
        if (x2 < 0) x2 = 0;
        if (x2 > fw) x2 = fw;
        if (y2 < 0) y2 = 0;
        if (y2 > fh) y2 = fh;
        if (x2 <= x1 || y2 <= y1) continue;
        r = '0;
        r.left = x1[14:0]; r.top = y1[14:0]; r.right = x2[14:0]; r.bottom = y2[14:0];
        r.score = boxes[order[i]].score;
        r.cls = boxes[order[i]].cls;
        r.src = order[i][cabs_pkg::SRC_W-1:0];
        r.ovf = ovf;
        kept_q = {kept_q, r};
        cnt++;
      end
      if (cnt == 0) begin
        r = '0;
        r.empty = 1; r.ovf = ovf; r.last = 1;
        kept_q = {kept_q, r};
      end else begin
        kept_q[kept_q.size()-1].last = 1;
      end
      nbox = 0;
      ovf = 0;
    endfunction

    task check(cabs_pkg::result_t got);
      cabs_pkg::result_t e;
      if (kept_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      e = kept_q.pop_front();
      if (got.left != e.left)     report($sformatf("left %0d want %0d", got.left, e.left));
      if (got.top != e.top)       report($sformatf("top %0d want %0d", got.top, e.top));
      if (got.right != e.right)   report($sformatf("right %0d want %0d", got.right, e.right));
      if (got.bottom != e.bottom)
        report($sformatf("bottom %0d want %0d", got.bottom, e.bottom));
      if (got.score != e.score)   report($sformatf("score %0d want %0d", got.score, e.score));
      if (got.cls != e.cls)       report($sformatf("class %0d want %0d", got.cls, e.cls));
      if (got.src != e.src)       report($sformatf("index %0d want %0d", got.src, e.src));
      if (got.empty != e.empty)   report($sformatf("empty %0b want %0b", got.empty, e.empty));
      if (got.ovf != e.ovf)       report($sformatf("overflow %0b want %0b", got.ovf, e.ovf));
      if (got.last != e.last)     report($sformatf("last %0b want %0b", got.last, e.last));
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [95:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  nms_scoreboard sb = new();
  int unsigned   cycles = 0;
  int unsigned   burst_left = 0;
  int unsigned   stall_mode = 0;

  class_aware_box_suppression dut (.*);

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Note accepted requests and check accepted results
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      sb.note_box(cand_box_t'(s_axis_tdata), s_axis_tlast);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      cabs_pkg::result_t r;
      r.left = m_axis_tdata[14:0];
      r.top = m_axis_tdata[29:15];
      r.right = m_axis_tdata[44:30];
      r.bottom = m_axis_tdata[59:45];
      r.score = m_axis_tdata[75:60];
      r.cls = m_axis_tdata[83:76];
      r.src = m_axis_tdata[93:84];
      r.empty = m_axis_tuser[0];
      r.ovf = m_axis_tuser[1];
      r.last = m_axis_tlast;
      sb.check(r);
    end
  end

  // Receiver stall pattern from a randomly picked mode, changed periodically
  always @(negedge clk) begin
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready <= (cycles % 8 < 3);
      default: m_axis_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  task automatic send_box(cand_box_t b, bit last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
  endtask

  // Drop valid, drain all results, then let the block settle
  task automatic wait_idle();
    @(negedge clk) s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.kept_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic cfg_all(logic [15:0] thr, logic [15:0] lim, logic [15:0] pl,
                         logic [15:0] pt, logic [15:0] w, logic [15:0] h);
    cfg_write(cabs_pkg::CFG_IOU_THRESHOLD, thr);
    cfg_write(cabs_pkg::CFG_MAX_RESULTS, lim);
    cfg_write(cabs_pkg::CFG_PAD_LEFT, pl);
    cfg_write(cabs_pkg::CFG_PAD_TOP, pt);
    cfg_write(cabs_pkg::CFG_FRAME_WIDTH, w);
    cfg_write(cabs_pkg::CFG_FRAME_HEIGHT, h);
  endtask

  function automatic cand_box_t mk(int l, int t, int r, int b, int s, int c);
    cand_box_t x;
    x.left = l[15:0]; x.top = t[15:0]; x.right = r[15:0]; x.bottom = b[15:0];
    x.score = s[15:0]; x.cls = c[7:0];
    return x;
  endfunction

  // Mostly clustered boxes of a few classes, some fully random fields
  function automatic cand_box_t rand_box();
    cand_box_t x;
    int cx, cy, w, h;
    if ($urandom_range(0, 9) == 0) begin
      x = cand_box_t'(88'({$urandom, $urandom, $urandom}));
    end else begin
      cx = $urandom_range(0, 1200) + 2000 * $urandom_range(0, 5);
      cy = $urandom_range(0, 1200) + 2000 * $urandom_range(0, 5);
      w = $urandom_range(0, 1500);
      h = $urandom_range(0, 1500);
      x = mk(cx - w, cy - h, cx + w, cy + h, $urandom_range(0, 7) * 8192 + $urandom_range(0, 3),
             $urandom_range(0, 2));
      if ($urandom_range(0, 4) == 0) x.score = 16'($urandom);
    end
    return x;
  endfunction

  task automatic random_frames(int unsigned items);
    int unsigned sent, n, k;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (k = 0; k < n; k++) send_box(rand_box(), k == n - 1);
      sent += n;
    end
    wait_idle();
  endtask

  initial begin
    int k;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed: extremes, suppression vs other class, ties, degenerate boxes
    send_box(mk(-32768, -32768, 32767, 32767, 65535, 255), 0);
    send_box(mk(-32768, -32768, 32767, 32767, 0, 0), 0);
    send_box(mk(100, 100, 900, 900, 40000, 1), 0);
    send_box(mk(110, 110, 910, 910, 40000, 1), 0);
    send_box(mk(110, 110, 910, 910, 40000, 2), 0);
    send_box(mk(500, 500, 400, 600, 50000, 1), 0);
    send_box(mk(700, 700, 700, 800, 30000, 1), 1);
    // Degenerate only: empty frame
    send_box(mk(300, 300, 200, 200, 12345, 3), 1);
    wait_idle();

    // Threshold zero, one result, pads at maximum and tiny frame
    cfg_all(16'd0, 16'd1, 16'd32767, 16'd32767, 16'd16, 16'd16);
    send_box(mk(32767, 32767, 32767, 32767, 1, 4), 0);
    send_box(mk(-5, -5, 32767, 32767, 2, 4), 1);
    wait_idle();
    cfg_all(16'd0, 16'd1, 16'd0, 16'd0, 16'd16, 16'd16);
    send_box(mk(0, 0, 8, 8, 9, 0), 0);
    send_box(mk(4, 4, 40, 40, 10, 0), 0);
    send_box(mk(100, 0, 200, 8, 11, 1), 1);
    wait_idle();
    // Zero and oversize result limits, full threshold, full frame
    cfg_all(16'd65535, 16'd0, 16'd0, 16'd0, 16'd32767, 16'd32767);
    send_box(mk(0, 0, 50, 50, 5, 0), 0);
    send_box(mk(0, 0, 50, 50, 6, 0), 1);
    wait_idle();
    cfg_write(cabs_pkg::CFG_MAX_RESULTS, 16'd100);
    send_box(mk(0, 0, 50, 50, 5, 0), 0);
    send_box(mk(0, 0, 50, 50, 6, 0), 0);
    send_box(mk(10, 10, 50, 50, 6, 0), 1);
    wait_idle();

    // Random phases over several settings
    cfg_all(16'd29491, 16'd64, 16'd0, 16'd0, 16'd10240, 16'd10240);
    random_frames(110);
    cfg_all(16'd16384, 16'd3, 16'd800, 16'd1200, 16'd8000, 16'd6000);
    random_frames(100);
    cfg_all(16'($urandom), 16'($urandom_range(1, 64)), 16'($urandom_range(0, 4000)),
            16'($urandom_range(0, 4000)), 16'($urandom_range(16, 32767)),
            16'($urandom_range(16, 32767)));
    random_frames(100);
    cfg_all(16'd45000, 16'd64, 16'd0, 16'd0, 16'd32767, 16'd32767);
    random_frames(110);

    // Capacity overflow: one box position and class repeated past the store size
    cfg_write(cabs_pkg::CFG_MAX_RESULTS, 16'd1);
    for (k = 0; k < cabs_pkg::MAX_BOXES + 6; k++)
      send_box(mk(1000, 1000, 3000, 3000, $urandom, 7), k == cabs_pkg::MAX_BOXES + 5);
    wait_idle();
    // Following frame must show no overflow
    send_box(mk(1000, 1000, 3000, 3000, 77, 7), 1);
    wait_idle();
    repeat (50) @(posedge clk);

    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cabs_pkg.sv
rtl/cabs_front.sv
rtl/cabs_queue.sv
rtl/cabs_back.sv
rtl/class_aware_box_suppression.sv
rtl/cabs_checker.sv
test/class_aware_box_suppression_test.sv
